// ===== hdl/button_debounce_click_classifier_macros.svh =====
// assertion helpers shared by the click classifier rtl
`ifndef BUTTON_DEBOUNCE_CLICK_CLASSIFIER_MACROS_SVH
`define BUTTON_DEBOUNCE_CLICK_CLASSIFIER_MACROS_SVH

// same-cycle implication, checked outside reset
`define BDCC_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define BDCC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/bdcc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bdcc_pkg
// Types and constants of the button debounce and click classifier.
// ----------------------------------------------------------------------------
package bdcc_pkg;

  localparam int unsigned STAMP_W = 32;
  localparam int unsigned WIN_W   = 16;
  localparam int unsigned EV_W    = 3;
  localparam int unsigned CNT_W   = 2;
  localparam int unsigned IDX_W   = 2;

  // event codes
  localparam logic [EV_W-1:0] EV_NONE            = 3'd0;
  localparam logic [EV_W-1:0] EV_SINGLE          = 3'd1;
  localparam logic [EV_W-1:0] EV_DOUBLE          = 3'd2;
  localparam logic [EV_W-1:0] EV_TRIPLE_PROGRESS = 3'd3;
  localparam logic [EV_W-1:0] EV_TRIPLE_COMPLETE = 3'd4;

  localparam logic [CNT_W-1:0] TRIPLE_TARGET = 2'd3;

  // register indexes
  localparam logic [IDX_W-1:0] REG_DEBOUNCE_TIME       = 2'd0;
  localparam logic [IDX_W-1:0] REG_DOUBLE_CLICK_WINDOW = 2'd1;
  localparam logic [IDX_W-1:0] REG_TRIPLE_GAP_WINDOW   = 2'd2;

  localparam logic [WIN_W-1:0] DEBOUNCE_RESET = 16'd50;
  localparam logic [WIN_W-1:0] WINDOW_RESET   = 16'd400;

  typedef struct packed {
    logic [WIN_W-1:0] debounce_time;
    logic [WIN_W-1:0] double_click_window;
    logic [WIN_W-1:0] triple_gap_window;
  } cfg_t;

  typedef struct packed {
    logic               prev_level;
    logic [STAMP_W-1:0] change_stamp;
    logic               press_taken;
    logic               click_pending;
    logic [STAMP_W-1:0] first_click_stamp;
    logic [CNT_W-1:0]   triple_count;
    logic [STAMP_W-1:0] triple_stamp;
  } state_t;

endpackage
`default_nettype wire

// ===== hdl/bdcc_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bdcc channel interfaces
// Valid/ready channels for polls, results and register writes.
// ----------------------------------------------------------------------------
interface bdcc_sample_if import bdcc_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [STAMP_W-1:0] now_ms;
  logic               pin_level;
  logic               triple_mode;

  modport source (output valid, now_ms, pin_level, triple_mode, input ready);
  modport sink   (input valid, now_ms, pin_level, triple_mode, output ready);
endinterface

interface bdcc_result_if import bdcc_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [EV_W-1:0]  event_res;
  logic [CNT_W-1:0] press_count;

  modport source (output valid, event_res, press_count, input ready);
  modport sink   (input valid, event_res, press_count, output ready);
endinterface

interface bdcc_cfg_if import bdcc_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] index;
  logic [WIN_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== hdl/bdcc_step.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bdcc_step
// One poll: debounce, press detection and click classification.
// ----------------------------------------------------------------------------
module bdcc_step import bdcc_pkg::*; (
  input  state_t             st,
  input  cfg_t               regs,
  input  logic [STAMP_W-1:0] now_ms,
  input  logic               pin_level,
  input  logic               triple_mode,
  output state_t             st_next,
  output logic [EV_W-1:0]    event_res,
  output logic [CNT_W-1:0]   press_count
);

  logic               level_change;
  logic [STAMP_W-1:0] held;
  logic [STAMP_W-1:0] since_first;
  logic [STAMP_W-1:0] since_triple;
  logic               low_long;
  logic               pressed;
  logic               first_late;
  logic               gap_over;
  logic [CNT_W-1:0]   count_inc;

  assign level_change = (pin_level != st.prev_level);
  // a level change restarts the hold time at zero
  assign held         = level_change ? '0 : (now_ms - st.change_stamp);
  assign since_first  = now_ms - st.first_click_stamp;
  assign since_triple = now_ms - st.triple_stamp;
  assign low_long     = !pin_level && (held >= {{(STAMP_W-WIN_W){1'b0}}, regs.debounce_time});
  assign pressed      = low_long && !st.press_taken;
  assign first_late   = since_first > {{(STAMP_W-WIN_W){1'b0}}, regs.double_click_window};
  assign gap_over     = since_triple > {{(STAMP_W-WIN_W){1'b0}}, regs.triple_gap_window};
  assign count_inc    = (gap_over ? '0 : st.triple_count) + 2'd1;

  always_comb begin
    st_next              = st;
    st_next.prev_level   = pin_level;
    st_next.change_stamp = level_change ? now_ms : st.change_stamp;
    if (low_long) begin
      st_next.press_taken = 1'b1;
    end else if (pin_level) begin
      st_next.press_taken = 1'b0;
    end
    event_res = EV_NONE;

    if (triple_mode) begin
      st_next.click_pending = 1'b0;
      if (pressed) begin
        st_next.triple_stamp = now_ms;
        if (count_inc == TRIPLE_TARGET) begin
          st_next.triple_count = '0;
          event_res            = EV_TRIPLE_COMPLETE;
        end else begin
          st_next.triple_count = count_inc;
          event_res            = EV_TRIPLE_PROGRESS;
        end
      end
    end else begin
      if (pressed) begin
        if (!st.click_pending) begin
          st_next.click_pending     = 1'b1;
          st_next.first_click_stamp = now_ms;
        end else if (!first_late) begin
          st_next.click_pending = 1'b0;
          event_res             = EV_DOUBLE;
        end else begin
          // late second press: report the old click, keep this one pending
          st_next.first_click_stamp = now_ms;
          event_res                 = EV_SINGLE;
        end
      end else if (st.click_pending && first_late) begin
        st_next.click_pending = 1'b0;
        event_res             = EV_SINGLE;
      end
    end
    press_count = st_next.triple_count;
  end

endmodule
`default_nettype wire

// ===== hdl/button_debounce_click_classifier.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// button_debounce_click_classifier
// Debounces an active-low button poll stream and classifies clicks.
// ----------------------------------------------------------------------------
// Each accepted poll gives exactly one result. Polls are taken one per
// cycle while input ready is high: a poll lands in an input register,
// then, once the result register is free, the step logic (three 32-bit
// timestamp subtracts and compares) updates the state and fills the
// result register. Input ready drops only while both stages hold data the
// result side has not taken. Register writes are accepted every cycle and
// should be made while no poll is in flight.
module button_debounce_click_classifier import bdcc_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  bdcc_sample_if.sink  sample,
  bdcc_result_if.source result,
  bdcc_cfg_if.sink     cfg
);

`include "button_debounce_click_classifier_macros.svh"

  cfg_t               regs;
  state_t             st;
  state_t             st_next;
  logic               s_valid;
  logic [STAMP_W-1:0] s_now_ms;
  logic               s_pin_level;
  logic               s_triple_mode;
  logic               r_valid;
  logic [EV_W-1:0]    r_event_res;
  logic [CNT_W-1:0]   r_press_count;
  logic [EV_W-1:0]    event_next;
  logic [CNT_W-1:0]   count_next;
  logic               r_free;
  logic               step_fire;

  assign r_free       = !r_valid || result.ready;
  assign step_fire    = s_valid && r_free;
  assign sample.ready = !s_valid || r_free;
  assign cfg.ready    = 1'b1;

  assign result.valid       = r_valid;
  assign result.event_res   = r_event_res;
  assign result.press_count = r_press_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.debounce_time       <= DEBOUNCE_RESET;
      regs.double_click_window <= WINDOW_RESET;
      regs.triple_gap_window   <= WINDOW_RESET;
    end else if (cfg.valid && cfg.ready) begin
      case (cfg.index)
        REG_DEBOUNCE_TIME:       regs.debounce_time       <= cfg.data;
        REG_DOUBLE_CLICK_WINDOW: regs.double_click_window <= cfg.data;
        REG_TRIPLE_GAP_WINDOW:   regs.triple_gap_window   <= cfg.data;
        default: ;
      endcase
    end
  end

  // input stage
  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid <= 1'b0;
    end else if (sample.valid && sample.ready) begin
      s_valid <= 1'b1;
    end else if (step_fire) begin
      s_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (sample.valid && sample.ready) begin
      s_now_ms      <= sample.now_ms;
      s_pin_level   <= sample.pin_level;
      s_triple_mode <= sample.triple_mode;
    end
  end

  bdcc_step u_step (
    .st          (st),
    .regs        (regs),
    .now_ms      (s_now_ms),
    .pin_level   (s_pin_level),
    .triple_mode (s_triple_mode),
    .st_next     (st_next),
    .event_res   (event_next),
    .press_count (count_next)
  );

  // state and result stage
  always_ff @(posedge clk) begin
    if (rst) begin
      st.prev_level        <= 1'b1;
      st.change_stamp      <= '0;
      st.press_taken       <= 1'b0;
      st.click_pending     <= 1'b0;
      st.first_click_stamp <= '0;
      st.triple_count      <= '0;
      st.triple_stamp      <= '0;
      r_valid              <= 1'b0;
    end else if (step_fire) begin
      st      <= st_next;
      r_valid <= 1'b1;
    end else if (result.ready) begin
      r_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step_fire) begin
      r_event_res   <= event_next;
      r_press_count <= count_next;
    end
  end

  `BDCC_ASSERT_NOW(a_count_range, clk, rst, 1'b1, st.triple_count != TRIPLE_TARGET,
    "triple count reached target in state")
  `BDCC_ASSERT_NOW(a_complete_clears, clk, rst,
    r_valid && (r_event_res == EV_TRIPLE_COMPLETE), r_press_count == '0,
    "triple complete with nonzero count")
  `BDCC_ASSERT_NEXT(a_triple_drops_pending, clk, rst, step_fire && s_triple_mode,
    !st.click_pending, "pending click survived a triple-mode poll")
  `BDCC_ASSERT_NEXT(a_double_clears, clk, rst, step_fire && (event_next == EV_DOUBLE),
    !st.click_pending, "pending click left after double click")
  `BDCC_ASSERT_NEXT(a_press_once, clk, rst,
    step_fire && (event_next == EV_TRIPLE_PROGRESS || event_next == EV_TRIPLE_COMPLETE),
    st.press_taken && !st.prev_level, "triple event without a held press")

endmodule
`default_nettype wire
